/* src/bkpe_pkg.sv */
// Shared types and constants for the bencode key path extractor.
`timescale 1ns / 1ps
package bkpe_pkg;
  localparam int STACK_DEPTH    = 256;
  localparam int MAX_PATH_BYTES = 16;
  localparam int SP_W           = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W         = $clog2(STACK_DEPTH);

  localparam logic [2:0] KIND_STR_BYTE  = 3'd0;
  localparam logic [2:0] KIND_STR_END   = 3'd1;
  localparam logic [2:0] KIND_INTEGER   = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  localparam logic [1:0] REG_PATH_LOW  = 2'd0;
  localparam logic [1:0] REG_PATH_HIGH = 2'd1;
  localparam logic [1:0] REG_PATH_LEN  = 2'd2;
  localparam logic [1:0] REG_CAP_LIMIT = 2'd3;

  typedef struct packed {
    logic       is_dict;
    logic       extract;
    logic [4:0] offset;
    logic [4:0] seglen;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  str_byte;
    logic [63:0] number;
  } result_t;
endpackage

/* src/bkpe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bkpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/bkpe_outq.sv */
// Result queue: takes up to two results per cycle, drives the output stream.
`timescale 1ns / 1ps
module bkpe_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          wr_count,
  input  bkpe_pkg::result_t   wr0,
  input  bkpe_pkg::result_t   wr1,
  output logic                has_room,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [71:0]         m_axis_tdata,  // string_byte, number_value
  output logic [2:0]          m_axis_tuser,  // kind
  output logic                m_axis_tlast
);
  bkpe_pkg::result_t q [4];
  logic [1:0] rp, wp;
  logic [2:0] cnt, cnt_next;
  logic       rd;

  assign rd            = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt != 3'd0);
  assign has_room      = (cnt <= 3'd2);
  assign m_axis_tdata  = {q[rp].number, q[rp].str_byte};
  assign m_axis_tuser  = q[rp].kind;
  assign m_axis_tlast  = (q[rp].kind != bkpe_pkg::KIND_STR_BYTE);

  always_comb begin
    cnt_next = cnt + {1'b0, wr_count} - {2'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp  <= 2'd0;
      wp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (wr_count != 2'd0) begin
        q[wp] <= wr0;
      end
      if (wr_count == 2'd2) begin
        q[wp + 2'd1] <= wr1;
      end
      wp  <= wp + wr_count;
      rp  <= rp + {1'b0, rd};
      cnt <= cnt_next;
    end
  end
endmodule

/* src/bencode_key_path_extractor_unit.sv */
// Top level: bencode parser with container stack in RAM and key path matching.
//
// Usage:
//   Input stream s_axis carries one message byte per transaction; tuser high
//   starts a new message (parse restarts before the byte), tlast marks the
//   final byte. Output stream m_axis carries results: tuser is the kind
//   (string byte, string end, integer, not found, error), tdata holds the
//   string byte and the 64-bit number, tlast is high on the final result.
//   Each byte is parsed in the cycle it is accepted; its results are
//   registered into the result queue. One byte per cycle is sustained while
//   the queue has room; a byte giving two results takes two queue entries. The
//   container stack lives in a single RAM with registered read; the entry
//   under the top is prefetched every cycle, so a close following an open
//   needs no stall. A four-entry result queue decouples the sides: input is
//   taken while the queue has room for two results, so a stalled receiver
//   holds input off once the queue fills. Reset empties the queue, clears the
//   parse and loads default registers (capture limit 32). Configuration via
//   cfg_we, cfg_index, cfg_data: the user must write only while idle; unchecked.
`timescale 1ns / 1ps
module bencode_key_path_extractor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // string_byte [7:0], number_value [71:8]
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int SPW = bkpe_pkg::SP_W;
  localparam int AW  = bkpe_pkg::ADDR_W;

  typedef enum logic [3:0] {
    M_ANY, M_DICT, M_DKLEN, M_DKMATCH, M_LIST,
    M_INT_FIRST, M_INT_DIGIT, M_STR_DIGIT, M_STR_CHAR, M_COMPLETE
  } mode_t;

  logic [63:0] path_lo, path_hi;
  logic [4:0]  path_len;
  logic [8:0]  cap_limit;

  mode_t            mode, mode_next, cur_mode;
  logic [SPW-1:0]   sp, sp_next, cur_sp;
  logic [63:0]      acc, acc_next, cur_acc;
  logic             neg, neg_next, cur_neg;
  logic             ext, ext_next, cur_ext;
  logic [4:0]       ofs, ofs_next, cur_ofs;
  logic [4:0]       sl, sl_next, cur_sl;
  logic [8:0]       cap, cap_next, cur_cap;
  logic             fin, fin_next, cur_fin;
  bkpe_pkg::frame_t top, top_next, rd_frame, wr_frame;
  logic             ram_we;
  logic [AW-1:0]    raddr;

  logic             in_acc, room;
  logic [1:0]       n_res;
  bkpe_pkg::result_t res [2];

  logic [127:0] path_all;
  logic [4:0]   eff_len;
  logic [7:0]   b;
  logic         is_dig;
  logic [63:0]  dig, acc10;
  logic [5:0]   nofs, kidx;
  logic [4:0]   nseg;
  logic [17:0]  zero_at;

  assign path_all = {path_hi, path_lo};
  assign eff_len  = (path_len > 5'(bkpe_pkg::MAX_PATH_BYTES)) ?
                    5'(bkpe_pkg::MAX_PATH_BYTES) : path_len;
  assign b        = s_axis_tdata;
  assign is_dig   = (b >= 8'h30) && (b <= 8'h39);
  assign dig      = {56'd0, b - 8'h30};
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  function automatic logic [7:0] path_byte(input logic [127:0] p, input logic [4:0] len,
                                           input logic [5:0] k);
    logic [3:0] i;
    i = 4'(k - 6'd1);
    if (k == 6'd0 || k > {1'b0, len}) begin
      return 8'd0;
    end
    return p[{i, 3'b000} +: 8];
  endfunction

  always_comb begin
    for (int j = 0; j < 18; j++) begin
      zero_at[j] = (path_byte(path_all, eff_len, 6'(j)) == 8'd0);
    end
  end

  always_comb begin
    nseg = 5'd0;
    for (int j = 17; j >= 0; j--) begin
      if (zero_at[j] && 6'(j) >= nofs) begin
        nseg = 5'(6'(j) - nofs);
      end
    end
  end

  always_comb begin
    cur_mode = s_axis_tuser ? M_ANY : mode;
    cur_sp   = s_axis_tuser ? '0 : sp;
    cur_acc  = s_axis_tuser ? 64'd0 : acc;
    cur_neg  = s_axis_tuser ? 1'b0 : neg;
    cur_ext  = s_axis_tuser ? 1'b1 : ext;
    cur_ofs  = s_axis_tuser ? 5'd0 : ofs;
    cur_sl   = s_axis_tuser ? 5'd0 : sl;
    cur_cap  = s_axis_tuser ? 9'd0 : cap;
    cur_fin  = s_axis_tuser ? 1'b0 : fin;
  end

  assign nofs  = {1'b0, cur_ofs} + {1'b0, cur_sl} + 6'd1;
  assign acc10 = (cur_acc << 3) + (cur_acc << 1);
  assign kidx  = {1'b0, cur_ofs} + {1'b0, cur_sl} - {1'b0, cur_acc[4:0]};

  always_comb begin
    logic       do_push, do_pop, do_any, do_err, do_int, do_dkl;
    logic [63:0] a_in, a_new, ival;
    mode_next = mode;
    sp_next   = sp;
    acc_next  = acc;
    neg_next  = neg;
    ext_next  = ext;
    ofs_next  = ofs;
    sl_next   = sl;
    cap_next  = cap;
    fin_next  = fin;
    top_next  = top;
    ram_we    = 1'b0;
    wr_frame  = '{is_dict: (cur_mode == M_DICT), extract: cur_ext,
                  offset: cur_ofs, seglen: cur_sl};
    n_res     = 2'd0;
    res[0]    = '0;
    res[1]    = '0;
    do_push = 1'b0; do_pop = 1'b0; do_any = 1'b0; do_err = 1'b0;
    do_int  = 1'b0; do_dkl = 1'b0;
    a_in    = cur_acc;
    a_new   = cur_acc - 64'd1;
    ival    = 64'd0;
    if (in_acc) begin
      mode_next = cur_mode;
      sp_next   = cur_sp;
      acc_next  = cur_acc;
      neg_next  = cur_neg;
      ext_next  = cur_ext;
      ofs_next  = cur_ofs;
      sl_next   = cur_sl;
      cap_next  = cur_cap;
      fin_next  = cur_fin;
      if (!cur_fin) begin
        case (cur_mode)
          M_ANY: do_any = 1'b1;
          M_INT_FIRST: begin
            acc_next  = 64'd0;
            mode_next = M_INT_DIGIT;
            neg_next  = (b == 8'h2d);
            if (b != 8'h2d) begin
              do_int = 1'b1;
              a_in   = 64'd0;
            end
          end
          M_INT_DIGIT: do_int = 1'b1;
          M_STR_DIGIT: begin
            if (b == 8'h3a) begin
              cap_next = 9'd0;
              if (cur_acc != 64'd0) begin
                mode_next = M_STR_CHAR;
              end else if (cur_ext) begin
                res[n_res[0]] = '{kind: bkpe_pkg::KIND_STR_END, str_byte: 8'd0,
                                  number: 64'd0};
                n_res = n_res + 2'd1;
                fin_next = 1'b1;
              end else begin
                do_pop = 1'b1;
              end
            end else if (is_dig) begin
              acc_next = acc10 + dig;
            end else begin
              do_err = 1'b1;
            end
          end
          M_STR_CHAR: begin
            if (cur_ext && cur_cap < cap_limit) begin
              res[n_res[0]] = '{kind: bkpe_pkg::KIND_STR_BYTE, str_byte: b,
                                number: 64'd0};
              n_res = n_res + 2'd1;
              cap_next = cur_cap + 9'd1;
            end
            acc_next = a_new;
            if (a_new == 64'd0) begin
              if (cur_ext) begin
                res[n_res[0]] = '{kind: bkpe_pkg::KIND_STR_END, str_byte: 8'd0,
                                  number: {55'd0, cap_next}};
                n_res = n_res + 2'd1;
                fin_next = 1'b1;
              end else begin
                do_pop = 1'b1;
              end
            end
          end
          M_LIST: begin
            if (b == 8'h65) begin
              do_pop = 1'b1;
            end else if (cur_sp >= SPW'(bkpe_pkg::STACK_DEPTH)) begin
              do_err = 1'b1;
            end else begin
              do_push = 1'b1;
              do_any  = 1'b1;
            end
          end
          M_DICT: begin
            if (b == 8'h65) begin
              do_pop = 1'b1;
            end else if (cur_sp >= SPW'(bkpe_pkg::STACK_DEPTH)) begin
              do_err = 1'b1;
            end else begin
              do_push = 1'b1;
              if (nofs > {1'b0, eff_len} + 6'd1) begin
                ext_next = 1'b0;
              end else begin
                ofs_next = nofs[4:0];
                sl_next  = nseg;
              end
              do_dkl = 1'b1;
              a_in   = 64'd0;
            end
          end
          M_DKLEN: do_dkl = 1'b1;
          M_DKMATCH: begin
            if (!(cur_acc <= {59'd0, cur_sl} &&
                  b == path_byte(path_all, eff_len, kidx))) begin
              ext_next = 1'b0;
            end
            acc_next = a_new;
            if (a_new == 64'd0) begin
              mode_next = M_ANY;
            end
          end
          default: do_err = 1'b1;
        endcase

        if (do_any) begin
          if (b == 8'h64) begin
            mode_next = M_DICT;
          end else if (b == 8'h6c) begin
            mode_next = M_LIST;
          end else if (b == 8'h69) begin
            mode_next = M_INT_FIRST;
          end else if (is_dig) begin
            acc_next  = dig;
            mode_next = M_STR_DIGIT;
          end else begin
            do_err = 1'b1;
          end
        end

        if (do_int) begin
          if (b == 8'h65) begin
            ival = neg_next ? (64'd0 - a_in) : a_in;
            if (cur_ext) begin
              res[n_res[0]] = '{kind: bkpe_pkg::KIND_INTEGER, str_byte: 8'd0,
                                number: ival};
              n_res = n_res + 2'd1;
              fin_next = 1'b1;
            end else begin
              do_pop = 1'b1;
            end
          end else if (is_dig) begin
            acc_next = ((a_in << 3) + (a_in << 1)) + dig;
          end else begin
            do_err = 1'b1;
          end
        end

        if (do_dkl) begin
          mode_next = M_DKLEN;
          if (b == 8'h3a) begin
            if (a_in == 64'd0) begin
              if (sl_next != 5'd0) begin
                ext_next = 1'b0;
              end
              mode_next = M_ANY;
            end else begin
              if (a_in != {59'd0, sl_next}) begin
                ext_next = 1'b0;
              end
              mode_next = M_DKMATCH;
            end
          end else if (is_dig) begin
            acc_next = ((a_in << 3) + (a_in << 1)) + dig;
          end else begin
            do_err = 1'b1;
          end
        end

        if (do_err) begin
          res[n_res[0]] = '{kind: bkpe_pkg::KIND_ERROR, str_byte: 8'd0, number: 64'd0};
          n_res = n_res + 2'd1;
          fin_next = 1'b1;
        end

        if (do_push) begin
          ram_we   = 1'b1;
          sp_next  = cur_sp + SPW'(1);
          top_next = wr_frame;
        end

        if (do_pop) begin
          if (cur_sp == '0) begin
            mode_next = M_COMPLETE;
          end else begin
            sp_next   = cur_sp - SPW'(1);
            mode_next = top.is_dict ? M_DICT : M_LIST;
            ext_next  = top.extract;
            ofs_next  = top.offset;
            sl_next   = top.seglen;
            top_next  = rd_frame;
          end
        end

        if (!fin_next && s_axis_tlast) begin
          res[n_res[0]] = '{kind: bkpe_pkg::KIND_NOT_FOUND, str_byte: 8'd0,
                            number: 64'd0};
          n_res = n_res + 2'd1;
          fin_next = 1'b1;
        end
      end
    end
  end

  assign raddr = AW'(sp_next - SPW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      path_lo   <= 64'd0;
      path_hi   <= 64'd0;
      path_len  <= 5'd0;
      cap_limit <= 9'd32;
      mode      <= M_ANY;
      sp        <= '0;
      acc       <= 64'd0;
      neg       <= 1'b0;
      ext       <= 1'b1;
      ofs       <= 5'd0;
      sl        <= 5'd0;
      cap       <= 9'd0;
      fin       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bkpe_pkg::REG_PATH_LOW:  path_lo   <= cfg_data;
          bkpe_pkg::REG_PATH_HIGH: path_hi   <= cfg_data;
          bkpe_pkg::REG_PATH_LEN:  path_len  <= cfg_data[4:0];
          bkpe_pkg::REG_CAP_LIMIT: cap_limit <= cfg_data[8:0];
          default: ;
        endcase
      end
      mode <= mode_next;
      sp   <= sp_next;
      acc  <= acc_next;
      neg  <= neg_next;
      ext  <= ext_next;
      ofs  <= ofs_next;
      sl   <= sl_next;
      cap  <= cap_next;
      fin  <= fin_next;
    end
    top <= top_next;
  end

  bkpe_ram #(
    .WIDTH(bkpe_pkg::FRAME_W),
    .DEPTH(bkpe_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_sp[AW-1:0]),
    .wdata (wr_frame),
    .raddr (raddr),
    .rdata (rd_frame)
  );

  bkpe_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .wr_count      (n_res),
    .wr0           (res[0]),
    .wr1           (res[1]),
    .has_room      (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );
endmodule

/* tb/sv/bencode_key_path_extractor_unit_test.sv */
// Testbench for the bencode key path extractor: scoreboard, predictor, stimulus.
`timescale 1ns / 1ps
module bencode_key_path_extractor_unit_test;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  sbyte;
    logic [63:0] num;
    logic        lst;
  } outcome_t;

  class outcome_board;
    outcome_t pending[$];
    int errors;
    function void note(outcome_t o);
      pending.push_back(o);
    endfunction
    function void check(outcome_t got);
      outcome_t w;
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d", got.kind);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.kind !== got.kind) begin
        $error("kind exp %0d got %0d", w.kind, got.kind); errors++;
      end
      if (w.sbyte !== got.sbyte) begin
        $error("string_byte exp %0h got %0h", w.sbyte, got.sbyte); errors++;
      end
      if (w.num !== got.num) begin
        $error("number_value exp %0d got %0d", $signed(w.num), $signed(got.num)); errors++;
      end
      if (w.lst !== got.lst) begin
        $error("last exp %0b got %0b", w.lst, got.lst); errors++;
      end
    endfunction
  endclass

  typedef enum logic [3:0] {
    P_ANY, P_DICT, P_DKLEN, P_DKMATCH, P_LIST, P_INT_FIRST, P_INT_DIGIT,
    P_STR_DIGIT, P_STR_CHAR, P_COMPLETE
  } pmode_t;

  typedef struct packed {
    pmode_t     mode;
    logic       ext;
    logic [4:0] ofs;
    logic [4:0] seg;
  } level_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tuser = 0, s_axis_tlast = 0;
  logic [7:0] s_axis_tdata = 0;
  wire s_axis_tready;
  wire m_axis_tvalid;
  logic m_axis_tready = 0;
  wire [71:0] m_axis_tdata;
  wire [2:0] m_axis_tuser;
  wire m_axis_tlast;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;

  bencode_key_path_extractor_unit uut (.*);

  always #6 clk = ~clk;

  outcome_board board = new();

  // predictor state
  logic [63:0] k_low, k_high;
  logic [4:0] k_len;
  logic [8:0] k_cap;
  pmode_t mode;
  level_t stk[bkpe_pkg::STACK_DEPTH];
  int unsigned sp;
  logic [63:0] acc;
  logic neg, ext, done;
  int unsigned ofs, seg, caught;

  int send_idle, recv_idle, idle_count;

  function automatic int unsigned key_len();
    return k_len > bkpe_pkg::MAX_PATH_BYTES ? bkpe_pkg::MAX_PATH_BYTES : k_len;
  endfunction

  function automatic logic [7:0] key_byte(int unsigned k);
    if (k == 0 || k > key_len()) return 0;
    k--;
    if (k < 8) return k_low[8*k +: 8];
    k -= 8;
    if (k < 8) return k_high[8*k +: 8];
    return 0;
  endfunction

  function automatic int unsigned seg_span(int unsigned o);
    int unsigned n = 0;
    while (n < 32 && key_byte(o + n) != 0) n++;
    return n;
  endfunction

  function automatic logic digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic give(logic [2:0] kd, logic [7:0] b, logic [63:0] v);
    outcome_t o;
    o.kind = kd; o.sbyte = b; o.num = v; o.lst = (kd != bkpe_pkg::KIND_STR_BYTE);
    board.note(o);
    if (kd != bkpe_pkg::KIND_STR_BYTE) done = 1;
  endtask

  task automatic restart();
    mode = P_ANY; sp = 0; acc = 0; neg = 0; ext = 1; ofs = 0; seg = 0;
    caught = 0; done = 0;
  endtask

  task automatic close_level();
    if (sp == 0) begin
      mode = P_COMPLETE;
      return;
    end
    sp--;
    mode = stk[sp].mode; ext = stk[sp].ext; ofs = stk[sp].ofs; seg = stk[sp].seg;
  endtask

  function automatic logic open_level();
    if (sp >= bkpe_pkg::STACK_DEPTH) return 0;
    stk[sp] = '{mode, ext, ofs[4:0], seg[4:0]};
    sp++;
    return 1;
  endfunction

  task automatic predict(logic [7:0] b, logic fst, logic lst);
    logic again = 1;
    int unsigned nofs;
    if (fst) restart();
    if (done) return;
    while (again) begin
      again = 0;
      case (mode)
        P_ANY: begin
          if (b == "d") mode = P_DICT;
          else if (b == "l") mode = P_LIST;
          else if (b == "i") mode = P_INT_FIRST;
          else if (digit(b)) begin
            acc = b - "0"; mode = P_STR_DIGIT;
          end else give(bkpe_pkg::KIND_ERROR, 0, 0);
        end
        P_INT_FIRST: begin
          acc = 0; mode = P_INT_DIGIT; neg = (b == "-");
          if (!neg) again = 1;
        end
        P_INT_DIGIT: begin
          if (b == "e") begin
            if (ext) give(bkpe_pkg::KIND_INTEGER, 0, neg ? -acc : acc);
            else close_level();
          end else if (digit(b)) acc = acc * 10 + (b - "0");
          else give(bkpe_pkg::KIND_ERROR, 0, 0);
        end
        P_STR_DIGIT: begin
          if (b == ":") begin
            caught = 0;
            if (acc != 0) mode = P_STR_CHAR;
            else if (ext) give(bkpe_pkg::KIND_STR_END, 0, 0);
            else close_level();
          end else if (digit(b)) acc = acc * 10 + (b - "0");
          else give(bkpe_pkg::KIND_ERROR, 0, 0);
        end
        P_STR_CHAR: begin
          if (ext && caught < k_cap) begin
            give(bkpe_pkg::KIND_STR_BYTE, b, 0); caught++;
          end
          acc--;
          if (acc == 0) begin
            if (ext) give(bkpe_pkg::KIND_STR_END, 0, caught);
            else close_level();
          end
        end
        P_LIST: begin
          if (b == "e") close_level();
          else if (!open_level()) give(bkpe_pkg::KIND_ERROR, 0, 0);
          else begin
            mode = P_ANY; again = 1;
          end
        end
        P_DICT: begin
          if (b == "e") close_level();
          else if (!open_level()) give(bkpe_pkg::KIND_ERROR, 0, 0);
          else begin
            nofs = ofs + seg + 1;
            if (nofs > key_len() + 1) ext = 0;
            else begin
              ofs = nofs; seg = seg_span(nofs);
            end
            acc = 0; mode = P_DKLEN; again = 1;
          end
        end
        P_DKLEN: begin
          if (b == ":") begin
            if (acc == 0) begin
              if (seg != 0) ext = 0;
              mode = P_ANY;
            end else begin
              if (acc != seg) ext = 0;
              mode = P_DKMATCH;
            end
          end else if (digit(b)) acc = acc * 10 + (b - "0");
          else give(bkpe_pkg::KIND_ERROR, 0, 0);
        end
        P_DKMATCH: begin
          if (!(acc <= seg && b == key_byte(ofs + seg - acc[31:0]))) ext = 0;
          acc--;
          if (acc == 0) mode = P_ANY;
        end
        default: give(bkpe_pkg::KIND_ERROR, 0, 0);
      endcase
      if (done) again = 0;
    end
    if (!done && lst) give(bkpe_pkg::KIND_NOT_FOUND, 0, 0);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check('{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[71:8], m_axis_tlast});
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, logic fst, logic lst);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= b; s_axis_tuser <= fst; s_axis_tlast <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict(b, fst, lst);
  endtask

  task automatic push_text(string t);
    for (int i = 0; i < t.len(); i++) push_byte(t[i], i == 0, i == t.len() - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      bkpe_pkg::REG_PATH_LOW: k_low = v;
      bkpe_pkg::REG_PATH_HIGH: k_high = v;
      bkpe_pkg::REG_PATH_LEN: k_len = v[4:0];
      default: k_cap = v[8:0];
    endcase
  endtask

  // key path "a\0bb" packed little-endian style: a,0,b,b
  task automatic set_path(string p, int cap);
    logic [127:0] pk = 0;
    for (int i = 0; i < p.len() && i < 16; i++) pk[8*i +: 8] = (p[i] == "/") ? 8'd0 : p[i];
    write_reg(bkpe_pkg::REG_PATH_LOW, pk[63:0]);
    write_reg(bkpe_pkg::REG_PATH_HIGH, pk[127:64]);
    write_reg(bkpe_pkg::REG_PATH_LEN, p.len());
    write_reg(bkpe_pkg::REG_CAP_LIMIT, cap);
  endtask

  function automatic string rnd_key();
    string s = "";
    int n = $urandom_range(2, 0);
    for (int i = 0; i < n; i++) s = {s, string'(8'("a" + $urandom_range(1)))};
    return s;
  endfunction

  function automatic string rnd_value(int depth);
    string s;
    int n;
    int c = $urandom_range(depth > 3 ? 1 : 3);
    case (c)
      0: begin
        s = $sformatf("%0d", $urandom_range(40000) - 20000);
        if ($urandom_range(9) == 0) s = "99999999999999999999";
        s = {"i", s, "e"};
      end
      1: begin
        n = $urandom_range(6);
        s = $sformatf("%0d:", n);
        repeat (n) s = {s, string'(8'($urandom_range(255)))};
      end
      2: begin
        s = "l";
        n = $urandom_range(2);
        repeat (n) s = {s, rnd_value(depth + 1)};
        s = {s, "e"};
      end
      default: begin
        s = "d";
        n = $urandom_range(2);
        repeat (n) begin
          string k = rnd_key();
          s = {s, $sformatf("%0d:", k.len()), k, rnd_value(depth + 1)};
        end
        s = {s, "e"};
      end
    endcase
    return s;
  endfunction

  task automatic random_message();
    string m = rnd_value(0);
    int r = $urandom_range(9);
    int p;
    if (r == 0) m = m.substr(0, $urandom_range(m.len() - 1));
    else if (r == 1) begin
      p = $urandom_range(m.len() - 1);
      m[p] = $urandom_range(255);
    end else if (r == 2) m = {m, "x"};
    push_text(m);
  endtask

  int sent;
  string pick[4] = '{"a", "a/b", "b/a/a", ""};

  initial begin
    send_idle = 7; recv_idle = 64; idle_count = 0;
    k_low = 0; k_high = 0; k_len = 0; k_cap = 32;
    restart();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_path("a/b", 4);
    push_text("d1:ad1:bi-42eee");
    push_text("d1:ad1:b6:abcdefee");
    push_text("i-9223372036854775808e");
    push_text("ie");
    push_text("i-e");
    push_text("d0:i5ee");
    push_text("x");
    push_text("i1ei");
    push_text("d1:ad1:b3:ab");
    push_byte(8'hff, 0, 1);
    push_byte(8'h00, 1, 1);
    push_text("d1:ad1:bd1:ai3eeee");
    drain();
    set_path("/a/bb//", 0);
    push_text("d0:d1:al2:xyeee");
    drain();
    set_path("aaaaaaaaaaaaaaaaaaaa", 256);
    write_reg(bkpe_pkg::REG_PATH_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bkpe_pkg::REG_PATH_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bkpe_pkg::REG_PATH_LEN, 5'd31);
    push_text("300:");
    repeat (300) push_byte(8'h61, 0, 0);
    push_byte("e", 0, 1);
    drain();
    // stack overflow
    set_path("", 32);
    push_byte("l", 1, 0);
    repeat (bkpe_pkg::STACK_DEPTH + 1) push_byte("l", 0, 0);
    push_byte("e", 0, 1);
    drain();
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 7 : ph == 1 ? 64 : 0;
      recv_idle = ph == 0 ? 64 : ph == 1 ? 7 : 0;
      for (int g = 0; g < 2; g++) begin
        set_path(pick[$urandom_range(3)], $urandom_range(1) ? $urandom_range(8) : 256);
        repeat (15) random_message();
        drain();
      end
    end
    drain();
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

/* bencode_key_path_extractor_unit.f */
src/bkpe_pkg.sv
src/bkpe_ram.sv
src/bkpe_outq.sv
src/bencode_key_path_extractor_unit.sv
tb/sv/bencode_key_path_extractor_unit_test.sv
